FILE: hw/rtl/bsc_pkg.sv
// Shared types and constants for the sensor compensation core.
// No dependencies.
`timescale 1ns / 1ps
package bsc_pkg;
  localparam int unsigned AddrWidth = 5;
  localparam int unsigned DivSideWidth = 54;

  typedef enum logic [2:0] {
    REG_OSS = 3'd0,
    REG_AC12 = 3'd1,
    REG_AC34 = 3'd2,
    REG_AC56 = 3'd3,
    REG_B12 = 3'd4,
    REG_MCMD = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic [1:0] oss;
    logic [31:0] ac12;
    logic [31:0] ac34;
    logic [31:0] ac56;
    logic [31:0] b12;
    logic [31:0] mcmd;
  } coef_t;

  typedef struct packed {
    logic signed [15:0] temperature_tenths;
    logic signed [31:0] pressure_pa;
    logic [15:0] pressure_tens_pa;
    logic div_fault;
  } result_t;
endpackage

FILE: hw/rtl/bsc_if.sv
// Valid/ready channel interfaces for raw sensor items and compensated results.
// No dependencies.
`timescale 1ns / 1ps
interface bsc_in_if;
  logic valid;
  logic ready;
  logic [15:0] raw_temperature;
  logic [18:0] raw_pressure;
  modport source (output valid, raw_temperature, raw_pressure, input ready);
  modport sink (input valid, raw_temperature, raw_pressure, output ready);
endinterface

interface bsc_out_if;
  logic valid;
  logic ready;
  logic signed [15:0] temperature_tenths;
  logic signed [31:0] pressure_pa;
  logic [15:0] pressure_tens_pa;
  logic div_fault;
  modport source (output valid, temperature_tenths, pressure_pa, pressure_tens_pa,
                  div_fault, input ready);
  modport sink (input valid, temperature_tenths, pressure_pa, pressure_tens_pa,
                div_fault, output ready);
endinterface

FILE: hw/rtl/bsc_regs.sv
// APB register file holding oversampling and calibration coefficients.
// Depends on bsc_pkg.
`timescale 1ns / 1ps
module bsc_regs (
  input  logic clk,
  input  logic rst,
  input  logic psel,
  input  logic penable,
  input  logic pwrite,
  input  logic [bsc_pkg::AddrWidth-1:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic pready,
  output bsc_pkg::coef_t coef
);
  logic wr;
  logic [2:0] idx;
  assign pready = 1'b1;
  assign wr = psel && penable && pwrite;
  assign idx = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      coef <= '0;
    end else if (wr) begin
      unique case (idx)
        bsc_pkg::REG_OSS: coef.oss <= pwdata[1:0];
        bsc_pkg::REG_AC12: coef.ac12 <= pwdata;
        bsc_pkg::REG_AC34: coef.ac34 <= pwdata;
        bsc_pkg::REG_AC56: coef.ac56 <= pwdata;
        bsc_pkg::REG_B12: coef.b12 <= pwdata;
        bsc_pkg::REG_MCMD: coef.mcmd <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      bsc_pkg::REG_OSS: prdata = {30'd0, coef.oss};
      bsc_pkg::REG_AC12: prdata = coef.ac12;
      bsc_pkg::REG_AC34: prdata = coef.ac34;
      bsc_pkg::REG_AC56: prdata = coef.ac56;
      bsc_pkg::REG_B12: prdata = coef.b12;
      bsc_pkg::REG_MCMD: prdata = coef.mcmd;
      default: prdata = 32'd0;
    endcase
  end
endmodule

FILE: hw/rtl/bsc_div.sv
// Pipelined unsigned 32-bit restoring divider, one quotient bit per stage.
// Carries a side payload along with each item; depends on bsc_pkg.
`timescale 1ns / 1ps
module bsc_div (
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  logic in_valid,
  input  logic [31:0] dividend,
  input  logic [31:0] divisor,
  input  logic [bsc_pkg::DivSideWidth-1:0] side_in,
  output logic out_valid,
  output logic [31:0] quotient,
  output logic [bsc_pkg::DivSideWidth-1:0] side_out
);
  logic vld [1:32];
  logic [31:0] rem [1:32];
  logic [31:0] quo [1:32];
  logic [31:0] dsr [1:32];
  logic [bsc_pkg::DivSideWidth-1:0] sd [1:32];

  for (genvar g = 0; g < 32; g++) begin : g_stage
    logic v_i;
    logic [31:0] r_i, q_i, d_i;
    logic [bsc_pkg::DivSideWidth-1:0] s_i;
    logic [32:0] trial;
    logic [32:0] shifted;
    if (g == 0) begin : g_head
      assign v_i = in_valid;
      assign r_i = 32'd0;
      assign q_i = dividend;
      assign d_i = divisor;
      assign s_i = side_in;
    end else begin : g_tail
      assign v_i = vld[g];
      assign r_i = rem[g];
      assign q_i = quo[g];
      assign d_i = dsr[g];
      assign s_i = sd[g];
    end
    assign shifted = {r_i, q_i[31]};
    assign trial = shifted - {1'b0, d_i};
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[g+1] <= 1'b0;
      end else if (en) begin
        vld[g+1] <= v_i;
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        if (!trial[32]) begin
          rem[g+1] <= trial[31:0];
          quo[g+1] <= {q_i[30:0], 1'b1};
        end else begin
          rem[g+1] <= shifted[31:0];
          quo[g+1] <= {q_i[30:0], 1'b0};
        end
        dsr[g+1] <= d_i;
        sd[g+1] <= s_i;
      end
    end
  end

  assign out_valid = vld[32];
  assign quotient = quo[32];
  assign side_out = sd[32];
endmodule

FILE: hw/rtl/bsc_pipe.sv
// Compensation datapath: temperature, b3/b4/b7, pressure divide and polish.
// Depends on bsc_pkg and bsc_div.
`timescale 1ns / 1ps
module bsc_pipe (
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  bsc_pkg::coef_t coef,
  input  logic in_valid,
  input  logic [15:0] ut,
  input  logic [18:0] up,
  output logic out_valid,
  output bsc_pkg::result_t res
);
  // coefficient fields
  logic signed [15:0] ac1, ac2, ac3, b1, b2, mc, md;
  logic [15:0] ac4, ac5, ac6;
  logic [1:0] oss;
  assign ac1 = coef.ac12[31:16];
  assign ac2 = coef.ac12[15:0];
  assign ac3 = coef.ac34[31:16];
  assign ac4 = coef.ac34[15:0];
  assign ac5 = coef.ac56[31:16];
  assign ac6 = coef.ac56[15:0];
  assign b1 = coef.b12[31:16];
  assign b2 = coef.b12[15:0];
  assign mc = coef.mcmd[31:16];
  assign md = coef.mcmd[15:0];
  assign oss = coef.oss;

  // stage 1: x1 for temperature
  logic s1_v;
  logic [18:0] s1_up;
  logic signed [31:0] s1_den, s1_x1;
  logic signed [16:0] dt;
  logic signed [33:0] prod1;
  logic signed [31:0] x1t;
  assign dt = $signed({1'b0, ut}) - $signed({1'b0, ac6});
  assign prod1 = dt * $signed({1'b0, ac5});
  assign x1t = 32'(prod1 >>> 15);
  always_ff @(posedge clk) begin
    if (rst) s1_v <= 1'b0;
    else if (en) s1_v <= in_valid;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s1_up <= up;
      s1_x1 <= x1t;
      s1_den <= x1t + 32'(md);
    end
  end

  // temperature divide, signed via magnitude
  logic [31:0] num_mag, den_mag;
  logic signed [31:0] mcs;
  logic tsign;
  assign mcs = 32'(mc) <<< 11;
  assign num_mag = mcs[31] ? -mcs : mcs;
  assign den_mag = s1_den[31] ? -s1_den : s1_den;
  assign tsign = mcs[31] ^ s1_den[31];
  logic d1_v;
  logic [31:0] d1_q;
  logic [bsc_pkg::DivSideWidth-1:0] d1_side;
  bsc_div u_div_t (
    .clk(clk), .rst(rst), .en(en), .in_valid(s1_v),
    .dividend(num_mag), .divisor(den_mag),
    .side_in({s1_den == 32'sd0, s1_up, s1_x1, tsign, 1'b0}),
    .out_valid(d1_v), .quotient(d1_q), .side_out(d1_side)
  );
  logic t_fault;
  logic [18:0] t_up;
  logic signed [31:0] t_x1;
  logic t_sign;
  assign t_fault = d1_side[bsc_pkg::DivSideWidth-1];
  assign t_up = d1_side[bsc_pkg::DivSideWidth-2 -: 19];
  assign t_x1 = d1_side[33:2];
  assign t_sign = d1_side[1];

  // stage 2: b5, b6
  logic s2_v, s2_f;
  logic [18:0] s2_up;
  logic signed [31:0] s2_b5, s2_b6;
  logic signed [31:0] x2t;
  assign x2t = t_sign ? -d1_q : d1_q;
  always_ff @(posedge clk) begin
    if (rst) s2_v <= 1'b0;
    else if (en) s2_v <= d1_v;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s2_f <= t_fault;
      s2_up <= t_up;
      s2_b5 <= t_x1 + x2t;
      s2_b6 <= t_x1 + x2t - 32'sd4000;
    end
  end

  // stage 3: b8, ac2*b6, ac3*b6
  logic s3_v, s3_f;
  logic [18:0] s3_up;
  logic signed [31:0] s3_b5, s3_b8, s3_x2a, s3_x1b;
  logic signed [63:0] sq;
  logic signed [47:0] p_ac2, p_ac3;
  assign sq = s2_b6 * s2_b6;
  assign p_ac2 = s2_b6 * ac2;
  assign p_ac3 = s2_b6 * ac3;
  always_ff @(posedge clk) begin
    if (rst) s3_v <= 1'b0;
    else if (en) s3_v <= s2_v;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s3_f <= s2_f;
      s3_up <= s2_up;
      s3_b5 <= s2_b5;
      s3_b8 <= 32'(sq >>> 12);
      s3_x2a <= 32'(p_ac2 >>> 11);
      s3_x1b <= 32'(p_ac3 >>> 13);
    end
  end

  // stage 4: b2*b8, b1*b8 -> x3 for b3, x3 for b4
  logic s4_v, s4_f;
  logic [18:0] s4_up;
  logic signed [31:0] s4_b5, s4_x3a, s4_x3b;
  logic signed [47:0] p_b2, p_b1;
  logic signed [31:0] x2b;
  logic signed [33:0] sum_b;
  assign p_b2 = s3_b8 * b2;
  assign p_b1 = s3_b8 * b1;
  assign x2b = 32'(p_b1 >>> 16);
  assign sum_b = 34'(s3_x1b) + 34'(x2b) + 34'sd2;
  always_ff @(posedge clk) begin
    if (rst) s4_v <= 1'b0;
    else if (en) s4_v <= s3_v;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s4_f <= s3_f;
      s4_up <= s3_up;
      s4_b5 <= s3_b5;
      s4_x3a <= 32'(p_b2 >>> 11) + s3_x2a;
      s4_x3b <= 32'(sum_b >>> 2);
    end
  end

  // stage 5: b3, b4
  logic s5_v, s5_f;
  logic [18:0] s5_up;
  logic signed [31:0] s5_b5, s5_b3;
  logic [31:0] s5_b4;
  logic signed [34:0] b3pre;
  logic [31:0] x3u;
  logic [47:0] b4prod;
  assign b3pre = ((35'(s4_x3a) + (35'(ac1) <<< 2)) <<< oss) + 35'sd2;
  assign x3u = s4_x3b + 32'sd32768;
  assign b4prod = x3u * ac4;
  always_ff @(posedge clk) begin
    if (rst) s5_v <= 1'b0;
    else if (en) s5_v <= s4_v;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s5_f <= s4_f;
      s5_up <= s4_up;
      s5_b5 <= s4_b5;
      s5_b3 <= 32'(b3pre >>> 2);
      s5_b4 <= b4prod[46:15];
    end
  end

  // stage 6: b7 and dividend selection
  logic s6_v, s6_f, s6_hi;
  logic signed [31:0] s6_b5;
  logic [31:0] s6_b4, s6_b7;
  logic [31:0] diffu;
  logic [15:0] scale;
  logic [47:0] b7prod;
  assign diffu = 32'({13'd0, s5_up}) - s5_b3;
  assign scale = 16'(32'd50000 >> oss);
  assign b7prod = diffu * scale;
  always_ff @(posedge clk) begin
    if (rst) s6_v <= 1'b0;
    else if (en) s6_v <= s5_v;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s6_f <= s5_f || (s5_b4 == 32'd0);
      s6_b5 <= s5_b5;
      s6_b4 <= s5_b4;
      s6_b7 <= b7prod[31:0];
    end
  end
  assign s6_hi = s6_b7[31];

  logic d2_v;
  logic [31:0] d2_q;
  logic [bsc_pkg::DivSideWidth-1:0] d2_side;
  bsc_div u_div_p (
    .clk(clk), .rst(rst), .en(en), .in_valid(s6_v),
    .dividend(s6_hi ? s6_b7 : {s6_b7[30:0], 1'b0}), .divisor(s6_b4),
    .side_in({20'd0, s6_f, s6_hi, s6_b5}),
    .out_valid(d2_v), .quotient(d2_q), .side_out(d2_side)
  );

  // stage 7: p, p>>8 squared, -7357*p
  logic s7_v, s7_f;
  logic signed [31:0] s7_b5, s7_p, s7_sq, s7_lin;
  logic signed [31:0] pq, p8;
  logic signed [47:0] plin;
  assign pq = d2_side[32] ? {d2_q[30:0], 1'b0} : d2_q;
  assign p8 = pq >>> 8;
  assign plin = pq * -48'sd7357;
  always_ff @(posedge clk) begin
    if (rst) s7_v <= 1'b0;
    else if (en) s7_v <= d2_v;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s7_f <= d2_side[33];
      s7_b5 <= d2_side[31:0];
      s7_p <= pq;
      s7_sq <= 32'(p8 * p8);
      s7_lin <= 32'(plin >>> 16);
    end
  end

  // stage 8: x1*3038, final p
  logic s8_v, s8_f;
  logic signed [31:0] s8_b5, s8_p;
  logic signed [47:0] p3038;
  logic signed [31:0] corr;
  assign p3038 = s7_sq * 48'sd3038;
  assign corr = 32'(p3038 >>> 16) + s7_lin + 32'sd3791;
  always_ff @(posedge clk) begin
    if (rst) s8_v <= 1'b0;
    else if (en) s8_v <= s7_v;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s8_f <= s7_f;
      s8_b5 <= s7_b5;
      s8_p <= s7_p + (corr >>> 4);
    end
  end

  // stage 9: temperature saturate, p/2+2
  logic s9_v, s9_f;
  logic signed [15:0] s9_t;
  logic signed [31:0] s9_p;
  logic signed [31:0] s9_h;
  logic signed [31:0] tt, half;
  assign tt = (s8_b5 + 32'sd8) >>> 4;
  assign half = ((s8_p[31] ? s8_p + 32'sd1 : s8_p) >>> 1) + 32'sd2;
  always_ff @(posedge clk) begin
    if (rst) s9_v <= 1'b0;
    else if (en) s9_v <= s8_v;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s9_f <= s8_f;
      s9_p <= s8_p;
      s9_h <= half;
      if (tt > 32'sd32767) s9_t <= 16'sh7fff;
      else if (tt < -32'sd32768) s9_t <= -16'sh8000;
      else s9_t <= tt[15:0];
    end
  end

  // stage 10: divide by 5; negative results saturate to zero anyway
  logic [63:0] recip;
  logic [31:0] tens;
  assign recip = {32'd0, s9_h} * 64'hCCCC_CCCD;
  assign tens = {2'd0, recip[63:34]};
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (en) out_valid <= s9_v;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      res.div_fault <= s9_f;
      res.temperature_tenths <= s9_f ? 16'sd0 : s9_t;
      res.pressure_pa <= s9_f ? 32'sd0 : s9_p;
      if (s9_f || s9_h[31]) res.pressure_tens_pa <= 16'd0;
      else if (tens > 32'd65535) res.pressure_tens_pa <= 16'hffff;
      else res.pressure_tens_pa <= tens[15:0];
    end
  end
endmodule

FILE: hw/rtl/barometric_sensor_compensation_core.sv
// Sensor compensation core: one item per cycle while the output is not held
// (ten arithmetic stages plus two 32-stage bit-per-stage dividers).
// The whole pipeline stalls together when the output is held, so a full
// pipe holds its items. Synchronous reset clears valids and coefficients to zero.
`timescale 1ns / 1ps
module barometric_sensor_compensation_core (
  input  logic clk,
  input  logic rst,
  bsc_in_if.sink in_ch,
  bsc_out_if.source out_ch,
  input  logic psel,
  input  logic penable,
  input  logic pwrite,
  input  logic [bsc_pkg::AddrWidth-1:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic pready
);
  bsc_pkg::coef_t coef;
  bsc_pkg::result_t res;
  logic en, pv;

  bsc_regs u_regs (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready), .coef(coef)
  );

  assign en = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = en;

  bsc_pipe u_pipe (
    .clk(clk), .rst(rst), .en(en), .coef(coef),
    .in_valid(in_ch.valid), .ut(in_ch.raw_temperature), .up(in_ch.raw_pressure),
    .out_valid(pv), .res(res)
  );

  assign out_ch.valid = pv;
  assign out_ch.temperature_tenths = res.temperature_tenths;
  assign out_ch.pressure_pa = res.pressure_pa;
  assign out_ch.pressure_tens_pa = res.pressure_tens_pa;
  assign out_ch.div_fault = res.div_fault;

  a_fault_zero: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.div_fault |-> out_ch.pressure_pa == 32'sd0)
    else $error("fault result not zero");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(res))
    else $error("stalled result changed");
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !out_ch.valid |-> in_ch.ready)
    else $error("stall without pending result");
endmodule

FILE: bench/bsc_compensation_checker.sv
// Checker for the sensor compensation core: watches the APB writes and both item channels,
// predicts each compensated result and compares it with what the core returns.
// Depends on bsc_pkg and the channel interfaces in bsc_if.sv.
`timescale 1ns / 1ps
module bsc_compensation_checker (
  input  logic clk,
  input  logic rst,
  bsc_in_if in_ch,
  bsc_out_if out_ch,
  input  logic psel,
  input  logic penable,
  input  logic pwrite,
  input  logic pready,
  input  logic [bsc_pkg::AddrWidth-1:0] paddr,
  input  logic [31:0] pwdata,
  output int mismatches,
  output int pending,
  output int results_seen,
  output int faults_seen
);
  bsc_pkg::coef_t coefs;
  bsc_pkg::result_t expected_results[$];

  function automatic longint w32(longint v);
    int s;
    s = int'(v[31:0]);
    return longint'(s);
  endfunction

  function automatic bsc_pkg::result_t compensate(logic [15:0] ut_w, logic [18:0] up_w,
                                                  bsc_pkg::coef_t c);
    longint ut, up, ac1, ac2, ac3, ac5, ac6, b1, b2, mc, md;
    longint x1, x2, x3, b3, b5, b6, b8, p, t, tens, den;
    longint unsigned ac4, b4, b7, q, mul;
    logic [31:0] x3u, diff;
    int oss;
    bsc_pkg::result_t r;
    r = '0;
    r.div_fault = 1'b1;
    ut = longint'(ut_w);
    up = longint'(up_w);
    oss = int'(c.oss);
    ac1 = longint'($signed(c.ac12[31:16]));
    ac2 = longint'($signed(c.ac12[15:0]));
    ac3 = longint'($signed(c.ac34[31:16]));
    ac4 = longint'(c.ac34[15:0]);
    ac5 = longint'(c.ac56[31:16]);
    ac6 = longint'(c.ac56[15:0]);
    b1 = longint'($signed(c.b12[31:16]));
    b2 = longint'($signed(c.b12[15:0]));
    mc = longint'($signed(c.mcmd[31:16]));
    md = longint'($signed(c.mcmd[15:0]));

    x1 = w32(((ut - ac6) * ac5) >>> 15);
    den = w32(x1 + md);
    if (den == 0) return r;
    x2 = w32((mc * 2048) / den);
    b5 = w32(x1 + x2);

    b6 = w32(b5 - 4000);
    b8 = w32((b6 * b6) >>> 12);
    x1 = w32((b2 * b8) >>> 11);
    x2 = w32((ac2 * b6) >>> 11);
    x3 = w32(x1 + x2);
    b3 = w32((((ac1 * 4 + x3) <<< oss) + 2) >>> 2);

    x1 = w32((ac3 * b6) >>> 13);
    x2 = w32((b1 * b8) >>> 16);
    x3 = w32((x1 + x2 + 2) >>> 2);
    x3u = 32'(x3 + 32768);
    b4 = ((ac4 * longint'(x3u)) >> 15) & 64'hFFFF_FFFF;
    if (b4 == 0) return r;

    diff = 32'(up - b3);
    mul = longint'(50000 >> oss);
    b7 = (longint'(diff) * mul) & 64'hFFFF_FFFF;
    if (b7 < 64'h8000_0000) q = (b7 * 2) / b4;
    else q = (b7 / b4) * 2;
    p = w32(longint'(q));

    x1 = w32((p >>> 8) * (p >>> 8));
    x1 = w32((x1 * 3038) >>> 16);
    x2 = w32((-7357 * p) >>> 16);
    p = w32(p + ((x1 + x2 + 3791) >>> 4));

    t = (b5 + 8) >>> 4;
    if (t > 32767) t = 32767;
    if (t < -32768) t = -32768;
    tens = (p / 2 + 2) / 5;
    if (tens < 0) tens = 0;
    if (tens > 65535) tens = 65535;

    r.temperature_tenths = t[15:0];
    r.pressure_pa = p[31:0];
    r.pressure_tens_pa = tens[15:0];
    r.div_fault = 1'b0;
    return r;
  endfunction

  task automatic report(string field, longint got, longint want);
    $display("mismatch at %0t: %s got %0d expected %0d", $realtime, field, got, want);
    mismatches++;
  endtask

  assign pending = expected_results.size();

  initial begin
    mismatches = 0;
    results_seen = 0;
    faults_seen = 0;
  end

  always @(posedge clk) begin
    bsc_pkg::result_t want;
    if (rst) begin
      coefs <= '0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr >> 2)
          bsc_pkg::REG_OSS: coefs.oss <= pwdata[1:0];
          bsc_pkg::REG_AC12: coefs.ac12 <= pwdata;
          bsc_pkg::REG_AC34: coefs.ac34 <= pwdata;
          bsc_pkg::REG_AC56: coefs.ac56 <= pwdata;
          bsc_pkg::REG_B12: coefs.b12 <= pwdata;
          bsc_pkg::REG_MCMD: coefs.mcmd <= pwdata;
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready)
        expected_results.push_back(compensate(in_ch.raw_temperature, in_ch.raw_pressure, coefs));
      if (out_ch.valid && out_ch.ready) begin
        if (expected_results.size() == 0) begin
          report("unexpected item", 1, 0);
        end else begin
          want = expected_results.pop_front();
          results_seen++;
          if (want.div_fault) faults_seen++;
          if (out_ch.temperature_tenths !== want.temperature_tenths)
            report("temperature_tenths", out_ch.temperature_tenths, want.temperature_tenths);
          if (out_ch.pressure_pa !== want.pressure_pa)
            report("pressure_pa", out_ch.pressure_pa, want.pressure_pa);
          if (out_ch.pressure_tens_pa !== want.pressure_tens_pa)
            report("pressure_tens_pa", out_ch.pressure_tens_pa, want.pressure_tens_pa);
          if (out_ch.div_fault !== want.div_fault)
            report("div_fault", out_ch.div_fault, want.div_fault);
        end
      end
    end
  end
endmodule

FILE: bench/tb_barometric_sensor_compensation_core.sv
// Testbench top for the sensor compensation core: drives APB setup and raw sensor items,
// shapes back-pressure, and reports the verdict from bsc_compensation_checker.
// Depends on bsc_pkg, bsc_if.sv, the core and the checker.
`timescale 1ns / 1ps
module tb_barometric_sensor_compensation_core;
  localparam int CycleLimit = 400000;
  localparam int DrainCycles = 100;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [bsc_pkg::AddrWidth-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  int mismatches, pending, results_seen, faults_seen;
  int cycles = 0;
  int items_sent = 0;
  int phases = 0;
  bit tx_idle = 1'b1;
  bit rx_idle = 1'b1;
  bit long_hold_req = 1'b0;

  bsc_in_if in_ch();
  bsc_out_if out_ch();

  barometric_sensor_compensation_core dut (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  bsc_compensation_checker checker_i (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch),
    .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
    .paddr(paddr), .pwdata(pwdata), .mismatches(mismatches), .pending(pending),
    .results_seen(results_seen), .faults_seen(faults_seen)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // receiver: random stalls, plus one long hold on request
  initial begin
    int burst, hold;
    burst = 0;
    hold = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold = 400;
      end
      if (hold > 0) begin
        hold--;
        out_ch.ready = 1'b0;
      end else begin
        if (rx_idle && burst == 0 && $urandom_range(0, 5) == 0) burst = $urandom_range(1, 8);
        if (burst > 0) begin
          burst--;
          out_ch.ready = 1'b0;
        end else begin
          out_ch.ready = 1'b1;
        end
      end
    end
  end

  task automatic reg_write(bsc_pkg::reg_idx_t idx, logic [31:0] value);
    @(negedge clk);
    psel = 1'b1;
    pwrite = 1'b1;
    penable = 1'b0;
    paddr = bsc_pkg::AddrWidth'(int'(idx) * 4);
    pwdata = value;
    @(negedge clk);
    penable = 1'b1;
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  task automatic load_coefs(logic [1:0] oss, logic [31:0] ac12, logic [31:0] ac34,
                            logic [31:0] ac56, logic [31:0] b12, logic [31:0] mcmd);
    reg_write(bsc_pkg::REG_OSS, {30'd0, oss});
    reg_write(bsc_pkg::REG_AC12, ac12);
    reg_write(bsc_pkg::REG_AC34, ac34);
    reg_write(bsc_pkg::REG_AC56, ac56);
    reg_write(bsc_pkg::REG_B12, b12);
    reg_write(bsc_pkg::REG_MCMD, mcmd);
    phases++;
  endtask

  task automatic send_sample(logic [15:0] ut, logic [18:0] up);
    @(negedge clk);
    if (tx_idle && $urandom_range(0, 4) == 0) begin
      in_ch.valid = 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
    in_ch.valid = 1'b1;
    in_ch.raw_temperature = ut;
    in_ch.raw_pressure = up;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic drain();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);
  endtask

  function automatic logic [15:0] jitter(int base, int span);
    return 16'(base + $urandom_range(0, 2 * span) - span);
  endfunction

  task automatic load_realistic(logic [1:0] oss);
    load_coefs(oss, {jitter(408, 200), jitter(-72, 60)}, {jitter(-14383, 2000), jitter(32741, 3000)},
               {jitter(32757, 3000), jitter(23153, 3000)}, {jitter(6190, 800), jitter(4, 4)},
               {jitter(-8711, 1000), jitter(2868, 500)});
  endtask

  task automatic send_random(int count, logic [1:0] oss);
    int base;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 4) != 0) begin
        base = 23843 << oss;
        send_sample(16'($urandom_range(20000, 35000)),
                    19'($urandom_range(base - (base / 3), base + (base / 3))));
      end else begin
        send_sample(16'($urandom), 19'($urandom));
      end
    end
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.raw_temperature = '0;
    in_ch.raw_pressure = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // reset coefficients: temperature divisor is zero
    send_sample(16'd27898, 19'd23843);
    send_sample(16'hFFFF, 19'h7FFFF);
    drain();

    // datasheet calibration and extremes of the raw fields
    load_coefs(2'd0, {16'sd408, -16'sd72}, {-16'sd14383, 16'd32741}, {16'd32757, 16'd23153},
               {16'sd6190, 16'sd4}, {-16'sd8711, 16'sd2868});
    send_sample(16'd27898, 19'd23843);
    send_sample(16'd0, 19'd0);
    send_sample(16'hFFFF, 19'h7FFFF);
    send_sample(16'd0, 19'h7FFFF);
    send_sample(16'hFFFF, 19'd0);
    send_sample(16'd27898, 19'h7FFFF);
    send_sample(16'h5555, 19'h2AAAA);
    send_sample(16'hAAAA, 19'h55555);
    drain();

    // pressure divisor is zero
    load_coefs(2'd3, {16'sd408, -16'sd72}, {-16'sd14383, 16'd0}, {16'd32757, 16'd23153},
               {16'sd6190, 16'sd4}, {-16'sd8711, 16'sd2868});
    send_sample(16'd27898, 19'd95372);
    send_sample(16'd30000, 19'h7FFFF);
    drain();

    // extreme coefficients: all ones, then most negative / largest
    load_coefs(2'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_random(12, 2'd3);
    drain();
    load_coefs(2'd0, 32'h8000_7FFF, 32'h8000_FFFF, 32'hFFFF_0000, 32'h7FFF_8000, 32'h7FFF_8000);
    send_random(12, 2'd0);
    drain();

    for (int oss = 0; oss < 4; oss++) begin
      load_realistic(2'(oss));
      send_random(50, 2'(oss));
      if (oss == 1) long_hold_req = 1'b1;
      send_random(40, 2'(oss));
      // sender pauses until every result is back
      @(negedge clk);
      in_ch.valid = 1'b0;
      while (pending != 0) @(negedge clk);
      send_random(20, 2'(oss));
      drain();
    end

    repeat (3) begin
      load_coefs(2'($urandom), $urandom, $urandom, $urandom, $urandom, $urandom);
      send_random(25, 2'($urandom));
      drain();
    end

    tx_idle = 1'b0;
    rx_idle = 1'b0;
    load_realistic(2'd2);
    send_random(60, 2'd2);
    drain();

    $display("sent %0d raw samples over %0d coefficient sets, %0d results checked",
             items_sent, phases, results_seen);
    $display("%0d results flagged a zero divisor, %0d mismatches", faults_seen, mismatches);
    if (mismatches == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule

FILE: barometric_sensor_compensation_core.f
hw/rtl/bsc_pkg.sv
hw/rtl/bsc_if.sv
hw/rtl/bsc_regs.sv
hw/rtl/bsc_div.sv
hw/rtl/bsc_pipe.sv
hw/rtl/barometric_sensor_compensation_core.sv
bench/bsc_compensation_checker.sv
bench/tb_barometric_sensor_compensation_core.sv
